### sv/vse_pkg.sv
// vse_pkg: shared types and codes for the value stack engine
// used by vse_seq, vse_obuf and value_stack_engine

package vse_pkg;

    localparam int OP_W    = 2;
    localparam int VAL_W   = 64;
    localparam int POS_W   = 8;
    localparam int CNT_W   = 9;
    localparam int FILL_W  = 9;
    localparam int ERR_W   = 2;

    localparam logic [OP_W-1:0] OP_PUSH    = 2'd0;
    localparam logic [OP_W-1:0] OP_POP     = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK    = 2'd2;
    localparam logic [OP_W-1:0] OP_REVERSE = 2'd3;

    localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_ARGUMENT = 2'd1;
    localparam logic [ERR_W-1:0] ERR_FULL     = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PEEK  = 5'b00010,
        S_RREAD = 5'b00100,
        S_WA    = 5'b01000,
        S_WB    = 5'b10000
    } t_state;

    typedef struct packed {
        logic [VAL_W-1:0]  read_value;
        logic [FILL_W-1:0] fill_level;
        logic [ERR_W-1:0]  error_code;
    } t_result;

endpackage

### sv/value_stack_engine.sv
// value_stack_engine: bounded value stack with push, pop, peek and range reverse
// depends on vse_pkg, vse_ram, vse_seq and vse_obuf
//
//   channel   direction   handshake                 payload
//   in        input       i_in_valid / o_in_stall   i_operation i_value i_position i_count
//   out       output      o_out_valid / i_out_stall o_read_value o_fill_level o_error_code
//
// push and pop finish in the idle state; peek adds one read of the entry memory
// reverse runs floor(count / 2) swaps: each swap is a read of both
// mirrored memory copies followed by two single-port writes
// reset clears the fill level and control; memory contents stay undefined
// a waiting result sits in the output register; one more result can wait in
// the skid entry, and while that is full the input is stalled

module value_stack_engine
    import vse_pkg::*;
#(
    parameter int STACK_DEPTH = 256,
    parameter int VALUE_WIDTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [OP_W-1:0]    i_operation,
    input  logic [VAL_W-1:0]   i_value,
    input  logic [POS_W-1:0]   i_position,
    input  logic [CNT_W-1:0]   i_count,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [VAL_W-1:0]   o_read_value,
    output logic [FILL_W-1:0]  o_fill_level,
    output logic [ERR_W-1:0]   o_error_code
);

    localparam int AW = $clog2(STACK_DEPTH);

    logic                   accept, seq_idle, skid_full;
    logic                   we, re_a, re_b;
    logic [AW-1:0]          waddr, raddr_a, raddr_b;
    logic [VALUE_WIDTH-1:0] wdata, rdata_a, rdata_b;
    logic                   res_valid;
    t_result                res, out;

    assign o_in_stall = !(seq_idle && !skid_full);
    assign accept     = i_in_valid && !o_in_stall;

    vse_seq #(
        .STACK_DEPTH (STACK_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_operation (i_operation),
        .i_value     (i_value),
        .i_position  (i_position),
        .i_count     (i_count),
        .o_idle      (seq_idle),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_re_a      (re_a),
        .o_raddr_a   (raddr_a),
        .i_rdata_a   (rdata_a),
        .o_re_b      (re_b),
        .o_raddr_b   (raddr_b),
        .i_rdata_b   (rdata_b),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // two copies with identical writes give two reads per cycle
    vse_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (STACK_DEPTH)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re_a),
        .i_raddr (raddr_a),
        .o_rdata (rdata_a)
    );

    vse_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (STACK_DEPTH)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re_b),
        .i_raddr (raddr_b),
        .o_rdata (rdata_b)
    );

    vse_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (out),
        .o_skid_full (skid_full)
    );

    assign o_read_value = out.read_value;
    assign o_fill_level = out.fill_level;
    assign o_error_code = out.error_code;

endmodule

### sv/vse_ram.sv
// vse_ram: generic single write port, single read port ram
// registered read data that holds when no read is issued; no dependencies

module vse_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/vse_seq.sv
// vse_seq: operation sequencer, fill level and memory access control
// depends on vse_pkg; drives two mirrored vse_ram copies in the top level

module vse_seq
    import vse_pkg::*;
#(
    parameter int STACK_DEPTH = 256,
    parameter int VALUE_WIDTH = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [OP_W-1:0]                i_operation,
    input  logic [VAL_W-1:0]               i_value,
    input  logic [POS_W-1:0]               i_position,
    input  logic [CNT_W-1:0]               i_count,
    output logic                           o_idle,
    output logic                           o_we,
    output logic [$clog2(STACK_DEPTH)-1:0] o_waddr,
    output logic [VALUE_WIDTH-1:0]         o_wdata,
    output logic                           o_re_a,
    output logic [$clog2(STACK_DEPTH)-1:0] o_raddr_a,
    input  logic [VALUE_WIDTH-1:0]         i_rdata_a,
    output logic                           o_re_b,
    output logic [$clog2(STACK_DEPTH)-1:0] o_raddr_b,
    input  logic [VALUE_WIDTH-1:0]         i_rdata_b,
    output logic                           o_res_valid,
    output t_result                        o_res
);

    localparam int AW     = $clog2(STACK_DEPTH);
    localparam int FW     = $clog2(STACK_DEPTH + 1);
    localparam int CW     = ((FW > CNT_W) ? FW : CNT_W) + 1;
    localparam int SWAP_W = CNT_W - 1;

    t_state            r_state, n_state;
    logic [FW-1:0]     r_fill, n_fill;
    logic [AW-1:0]     r_a, n_a;
    logic [AW-1:0]     r_b, n_b;
    logic [SWAP_W-1:0] r_swaps, n_swaps;

    logic [CW-1:0] fill_c, pos_c, cnt_c;
    logic [CW-1:0] fill_sub, top_addr, run_low, run_end, n_fill_c;
    logic          push_ok, pop_ok, peek_ok, rev_ok;

    assign fill_c   = CW'(r_fill);
    assign pos_c    = CW'(i_position);
    assign cnt_c    = CW'(i_count);
    assign fill_sub = fill_c - cnt_c;
    assign top_addr = fill_c - CW'(1) - pos_c;
    assign run_end  = pos_c + cnt_c;
    assign run_low  = fill_c - run_end;
    assign push_ok  = fill_c < CW'(STACK_DEPTH);
    assign pop_ok   = cnt_c <= fill_c;
    assign peek_ok  = pos_c < fill_c;
    assign rev_ok   = run_end <= fill_c;
    assign n_fill_c = CW'(n_fill);

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_a         = r_a;
        n_b         = r_b;
        n_swaps     = r_swaps;
        o_we        = 1'b0;
        o_waddr     = r_a;
        o_wdata     = i_value[VALUE_WIDTH-1:0];
        o_re_a      = 1'b0;
        o_raddr_a   = r_a;
        o_re_b      = 1'b0;
        o_raddr_b   = r_b;
        o_res_valid = 1'b0;
        o_res.read_value = '0;
        o_res.error_code = ERR_NONE;

        case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    case (i_operation)
                        OP_PUSH: begin
                            o_res_valid = 1'b1;
                            if (push_ok) begin
                                o_we    = 1'b1;
                                o_waddr = r_fill[AW-1:0];
                                n_fill  = r_fill + FW'(1);
                            end else begin
                                o_res.error_code = ERR_FULL;
                            end
                        end
                        OP_POP: begin
                            o_res_valid = 1'b1;
                            if (pop_ok) begin
                                n_fill = fill_sub[FW-1:0];
                            end else begin
                                o_res.error_code = ERR_ARGUMENT;
                            end
                        end
                        OP_PEEK: begin
                            if (peek_ok) begin
                                o_re_a    = 1'b1;
                                o_raddr_a = top_addr[AW-1:0];
                                n_state   = S_PEEK;
                            end else begin
                                o_res_valid      = 1'b1;
                                o_res.error_code = ERR_ARGUMENT;
                            end
                        end
                        OP_REVERSE: begin
                            if (!rev_ok) begin
                                o_res_valid      = 1'b1;
                                o_res.error_code = ERR_ARGUMENT;
                            end else if (i_count[CNT_W-1:1] == '0) begin
                                o_res_valid = 1'b1;
                            end else begin
                                n_a     = top_addr[AW-1:0];
                                n_b     = run_low[AW-1:0];
                                n_swaps = i_count[CNT_W-1:1];
                                n_state = S_RREAD;
                            end
                        end
                        default: begin
                            o_res_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_PEEK: begin
                o_res_valid      = 1'b1;
                o_res.read_value = VAL_W'(i_rdata_a);
                n_state          = S_IDLE;
            end
            S_RREAD: begin
                o_re_a  = 1'b1;
                o_re_b  = 1'b1;
                n_state = S_WA;
            end
            S_WA: begin
                // read data is held, so the upper entry is written first
                o_we    = 1'b1;
                o_waddr = r_a;
                o_wdata = i_rdata_b;
                n_state = S_WB;
            end
            S_WB: begin
                o_we    = 1'b1;
                o_waddr = r_b;
                o_wdata = i_rdata_a;
                n_a     = r_a - AW'(1);
                n_b     = r_b + AW'(1);
                n_swaps = r_swaps - SWAP_W'(1);
                if (r_swaps == SWAP_W'(1)) begin
                    o_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_state = S_RREAD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        o_res.fill_level = n_fill_c[FILL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a     <= n_a;
        r_b     <= n_b;
        r_swaps <= n_swaps;
    end

    assign o_idle = (r_state == S_IDLE);

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_fill) <= CW'(STACK_DEPTH))
        else $error("fill level beyond stack depth");

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |-> r_state == S_IDLE)
        else $error("item taken while sequencer busy");

    a_swap_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RREAD || r_state == S_WA) |-> r_a > r_b)
        else $error("reverse swap pointers crossed");

    a_fill_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |=> $stable(r_fill))
        else $error("fill level changed during multi-cycle operation");

endmodule

### sv/vse_obuf.sv
// vse_obuf: result output register with one skid entry
// depends on vse_pkg for the result type

module vse_obuf
    import vse_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_res_valid,
    input  t_result i_res,
    input  logic    i_out_stall,
    output logic    o_out_valid,
    output t_result o_out,
    output logic    o_skid_full
);

    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;
    logic    take, load_out;

    assign take     = r_out_valid && !i_out_stall;
    assign load_out = !r_out_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (load_out) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (i_res_valid) begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (load_out) begin
                r_out <= r_skid;
            end
        end else if (i_res_valid) begin
            if (load_out) begin
                r_out <= i_res;
            end else begin
                r_skid <= i_res;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_skid_full = r_skid_valid;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_res_valid)
        else $error("result arrived with skid entry full");

endmodule
